[hdl/thpu_pkg.sv]
package thpu_pkg;

    // configuration register indexes
    typedef enum logic [2:0] {
        CFG_IMAGE_WIDTH   = 3'd0,
        CFG_IMAGE_HEIGHT  = 3'd1,
        CFG_CHANNELS      = 3'd2,
        CFG_SAMPLE_SIZE   = 3'd3,
        CFG_BIG_ENDIAN    = 3'd4,
        CFG_PLANAR_LAYOUT = 3'd5
    } cfg_index_t;

    localparam int unsigned CFG_INDEX_W = 3;
    localparam int unsigned CFG_DATA_W  = 16;

    // sample width codes
    localparam logic [1:0] SIZE_8BIT  = 2'd0;
    localparam logic [1:0] SIZE_16BIT = 2'd1;

    typedef struct packed {
        logic [31:0] sample_in;
    } in_beat_t;

    typedef struct packed {
        logic [31:0] sample_out;
        logic        end_of_row;
        logic        end_of_image;
    } out_beat_t;

    // per-item position flags from the sequencer
    typedef struct packed {
        logic first_column;
        logic row_end;
        logic image_end;
    } item_flags_t;

    function automatic logic [31:0] sample_mask(input logic [1:0] size);
        logic [31:0] m;
        unique case (size)
            SIZE_8BIT:  m = 32'h0000_00FF;
            SIZE_16BIT: m = 32'h0000_FFFF;
            default:    m = 32'hFFFF_FFFF;
        endcase
        return m;
    endfunction

    // byte reversal within the sample width, input already masked
    function automatic logic [31:0] swap_bytes(input logic [31:0] v, input logic [1:0] size);
        logic [31:0] r;
        unique case (size)
            SIZE_8BIT:  r = v;
            SIZE_16BIT: r = {16'h0000, v[7:0], v[15:8]};
            default:    r = {v[7:0], v[15:8], v[23:16], v[31:24]};
        endcase
        return r;
    endfunction

endpackage

[hdl/thpu_stream_if.sv]
interface thpu_stream_if #(
    parameter type payload_t = logic
);
    logic     valid;
    logic     ready;
    payload_t payload;

    modport source (output valid, output payload, input ready);
    modport sink (input valid, input payload, output ready);
endinterface

[hdl/thpu_seq.sv]
module thpu_seq #(
    parameter int unsigned MAX_CHANNELS = 8,
    parameter int unsigned CH_W = 3
) (
    input  logic                      clk,
    input  logic                      rst_n,
    input  logic                      advance,
    input  logic [15:0]               image_width,
    input  logic [15:0]               image_height,
    input  logic [3:0]                channels,
    input  logic                      planar_layout,
    output logic [CH_W-1:0]           channel,
    output thpu_pkg::item_flags_t     flags
);

    localparam logic [4:0] MAX_CH = 5'(MAX_CHANNELS);

    logic [15:0]     column_count_reg, column_count_next;
    logic [15:0]     row_count_reg, row_count_next;
    logic [CH_W-1:0] channel_index_reg, channel_index_next;
    logic [CH_W-1:0] plane_index_reg, plane_index_next;

    logic [15:0] width_eff, height_eff;
    logic [4:0]  ch_eff, ci_full;
    logic        last_ch, col_last, row_last, plane_last;

    always_comb
    begin
        width_eff  = (image_width == 16'd0) ? 16'd1 : image_width;
        height_eff = (image_height == 16'd0) ? 16'd1 : image_height;
        if (channels == 4'd0)
        begin
            ch_eff = 5'd1;
        end
        else if ({1'b0, channels} > MAX_CH)
        begin
            ch_eff = MAX_CH;
        end
        else
        begin
            ch_eff = {1'b0, channels};
        end

        ci_full = planar_layout ? 5'd0 : 5'(channel_index_reg);
        if (ci_full >= ch_eff)
        begin
            ci_full = ch_eff - 5'd1;
        end

        last_ch    = planar_layout || ((ci_full + 5'd1) >= ch_eff);
        col_last   = ({1'b0, column_count_reg} + 17'd1) >= {1'b0, width_eff};
        row_last   = ({1'b0, row_count_reg} + 17'd1) >= {1'b0, height_eff};
        plane_last = (5'(plane_index_reg) + 5'd1) >= ch_eff;

        channel            = ci_full[CH_W-1:0];
        flags.first_column = (column_count_reg == 16'd0);
        flags.row_end      = last_ch && col_last;
        flags.image_end    = last_ch && col_last && row_last && (!planar_layout || plane_last);
    end

    always_comb
    begin
        column_count_next  = column_count_reg;
        row_count_next     = row_count_reg;
        channel_index_next = channel_index_reg;
        plane_index_next   = plane_index_reg;
        if (advance)
        begin
            if (last_ch)
            begin
                channel_index_next = '0;
                if (col_last)
                begin
                    column_count_next = 16'd0;
                    if (row_last)
                    begin
                        row_count_next = 16'd0;
                        if (!planar_layout || plane_last)
                        begin
                            plane_index_next = '0;
                        end
                        else
                        begin
                            plane_index_next = plane_index_reg + 1'b1;
                        end
                    end
                    else
                    begin
                        row_count_next = row_count_reg + 16'd1;
                    end
                end
                else
                begin
                    column_count_next = column_count_reg + 16'd1;
                end
            end
            else
            begin
                channel_index_next = CH_W'(ci_full + 5'd1);
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            column_count_reg  <= 16'd0;
            row_count_reg     <= 16'd0;
            channel_index_reg <= '0;
            plane_index_reg   <= '0;
        end
        else
        begin
            column_count_reg  <= column_count_next;
            row_count_reg     <= row_count_next;
            channel_index_reg <= channel_index_next;
            plane_index_reg   <= plane_index_next;
        end
    end

endmodule

[hdl/tiff_horizontal_predictor_undo_top.sv]
// path: an accepted sample is held in the stage 1 register, then in the output register that drives the result port
// throughput: one sample per cycle unless the output stalls; per-channel history read at
//   accept, written on s1_advance, a one-entry forwarding register covers the overlap
// reset: rst_n asynchronous active low; counters, valids and registers return to defaults
//   (width 1, height 1, channels 1, others 0); the history memory is not cleared
module tiff_horizontal_predictor_undo_top #(
    parameter int unsigned MAX_CHANNELS = 8
) (
    input  logic                               clk,
    input  logic                               rst_n,
    input  logic                               write_enable,
    input  logic [thpu_pkg::CFG_INDEX_W-1:0]   reg_index,
    input  logic [thpu_pkg::CFG_DATA_W-1:0]    write_data,
    thpu_stream_if.sink                        sample_stream,
    thpu_stream_if.source                      result_stream
);

    localparam int unsigned CH_W = (MAX_CHANNELS > 1) ? $clog2(MAX_CHANNELS) : 1;

    // configuration registers
    logic [15:0] image_width_reg, image_height_reg;
    logic [3:0]  channels_reg;
    logic [1:0]  sample_size_reg;
    logic        big_endian_reg, planar_layout_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            image_width_reg   <= 16'd1;
            image_height_reg  <= 16'd1;
            channels_reg      <= 4'd1;
            sample_size_reg   <= thpu_pkg::SIZE_8BIT;
            big_endian_reg    <= 1'b0;
            planar_layout_reg <= 1'b0;
        end
        else if (write_enable)
        begin
            unique case (reg_index)
                thpu_pkg::CFG_IMAGE_WIDTH:   image_width_reg   <= write_data;
                thpu_pkg::CFG_IMAGE_HEIGHT:  image_height_reg  <= write_data;
                thpu_pkg::CFG_CHANNELS:      channels_reg      <= write_data[3:0];
                thpu_pkg::CFG_SAMPLE_SIZE:   sample_size_reg   <= write_data[1:0];
                thpu_pkg::CFG_BIG_ENDIAN:    big_endian_reg    <= write_data[0];
                thpu_pkg::CFG_PLANAR_LAYOUT: planar_layout_reg <= write_data[0];
                default:                     ;
            endcase
        end
    end

    // pipeline handshake: stage 1 holds the accepted beat, the output register is the skid
    logic s1_valid_reg, out_valid_reg;
    logic s1_advance, in_accept;

    assign s1_advance          = s1_valid_reg && (!out_valid_reg || result_stream.ready);
    assign sample_stream.ready = !s1_valid_reg || s1_advance;
    assign in_accept           = sample_stream.valid && sample_stream.ready;

    // row / channel / plane position of the beat being accepted
    logic [CH_W-1:0]       acc_channel;
    thpu_pkg::item_flags_t acc_flags;

    thpu_seq #(
        .MAX_CHANNELS (MAX_CHANNELS),
        .CH_W         (CH_W)
    ) u_seq (
        .clk           (clk),
        .rst_n         (rst_n),
        .advance       (in_accept),
        .image_width   (image_width_reg),
        .image_height  (image_height_reg),
        .channels      (channels_reg),
        .planar_layout (planar_layout_reg),
        .channel       (acc_channel),
        .flags         (acc_flags)
    );

    // previous restored sample per channel, native byte order
    logic [31:0] history_mem [MAX_CHANNELS];
    logic [31:0] rd_data_reg;

    // stage 1 payload
    logic [31:0]           s1_sample_reg;
    logic [CH_W-1:0]       s1_channel_reg;
    thpu_pkg::item_flags_t s1_flags_reg;

    // most recent history write, covers a read that raced the write
    logic            fwd_valid_reg;
    logic [CH_W-1:0] fwd_channel_reg;
    logic [31:0]     fwd_data_reg;

    // stage 1 datapath
    logic [31:0] mask, native_in, prev, restored, result;

    always_comb
    begin
        mask      = thpu_pkg::sample_mask(sample_size_reg);
        native_in = s1_sample_reg & mask;
        if (big_endian_reg)
        begin
            native_in = thpu_pkg::swap_bytes(native_in, sample_size_reg);
        end
        prev = (fwd_valid_reg && (fwd_channel_reg == s1_channel_reg)) ? fwd_data_reg
                                                                        : rd_data_reg;
        // first pixel of a row passes through
        restored = s1_flags_reg.first_column ? native_in : ((native_in + prev) & mask);
        result   = big_endian_reg ? thpu_pkg::swap_bytes(restored, sample_size_reg)
                                  : restored;
    end

    always_ff @(posedge clk)
    begin
        if (in_accept)
        begin
            rd_data_reg <= history_mem[acc_channel];
        end
        if (s1_advance)
        begin
            history_mem[s1_channel_reg] <= restored;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_accept)
        begin
            s1_sample_reg  <= sample_stream.payload.sample_in;
            s1_channel_reg <= acc_channel;
            s1_flags_reg   <= acc_flags;
        end
        if (s1_advance)
        begin
            fwd_channel_reg <= s1_channel_reg;
            fwd_data_reg    <= restored;
        end
    end

    // output register
    thpu_pkg::out_beat_t out_beat_reg;

    always_ff @(posedge clk)
    begin
        if (s1_advance)
        begin
            out_beat_reg.sample_out   <= result;
            out_beat_reg.end_of_row   <= s1_flags_reg.row_end;
            out_beat_reg.end_of_image <= s1_flags_reg.image_end;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
            fwd_valid_reg <= 1'b0;
        end
        else
        begin
            if (in_accept)
            begin
                s1_valid_reg <= 1'b1;
            end
            else if (s1_advance)
            begin
                s1_valid_reg <= 1'b0;
            end

            if (s1_advance)
            begin
                out_valid_reg <= 1'b1;
                fwd_valid_reg <= 1'b1;
            end
            else if (result_stream.ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    assign result_stream.valid   = out_valid_reg;
    assign result_stream.payload = out_beat_reg;

endmodule

[verif/testbench.sv]
`timescale 1ns / 100ps

module testbench;

    // sample width code with no name in the package
    localparam logic [1:0] SIZE_32BIT = 2'd2;

    localparam int unsigned HIST_DEPTH  = 8;
    localparam int unsigned RANDOM_BEATS = 1200;
    localparam int unsigned CYCLE_LIMIT = 300000;
    localparam int unsigned MAX_GAP     = 14;
    // settle time after the last owed result is back
    localparam int unsigned SETTLE_CYCLES = 6;

    // one step of the directed list: a register write or a sample beat
    typedef struct {
        bit                   is_cfg;
        thpu_pkg::cfg_index_t idx;
        logic [31:0]          value;
        bit                   typed;
        thpu_pkg::out_beat_t  want;
    } dir_row_t;

    logic                             clk;
    logic                             rst_n;
    logic                             write_enable;
    logic [thpu_pkg::CFG_INDEX_W-1:0] reg_index;
    logic [thpu_pkg::CFG_DATA_W-1:0]  write_data;

    thpu_stream_if #(.payload_t(thpu_pkg::in_beat_t))  sample_if ();
    thpu_stream_if #(.payload_t(thpu_pkg::out_beat_t)) result_if ();

    tiff_horizontal_predictor_undo_top i_dut (
        .clk           (clk),
        .rst_n         (rst_n),
        .write_enable  (write_enable),
        .reg_index     (reg_index),
        .write_data    (write_data),
        .sample_stream (sample_if),
        .result_stream (result_if)
    );

    // register copies as the block should hold them
    logic [15:0] cfg_width;
    logic [15:0] cfg_height;
    logic [3:0]  cfg_channels;
    logic [1:0]  cfg_size;
    logic        cfg_big;
    logic        cfg_planar;

    // predictor state: last restored native sample per channel and the position counters
    logic [31:0] hist_sample [HIST_DEPTH];
    logic [15:0] col_cnt;
    logic [2:0]  chan_idx;
    logic [15:0] row_cnt;
    logic [2:0]  plane_idx;

    // restored samples still owed by the block, oldest first
    thpu_pkg::out_beat_t pending_results [$];
    dir_row_t            dir_rows [$];

    int  error_count;
    int  samples_sent;
    int  results_seen;
    int  row_ends_seen;
    int  image_ends_seen;
    int  settings_used;
    int  cycle_count;
    bit  src_idle_en;
    bit  snk_idle_en;

    // 4 ns clock
    initial
    begin
        clk = 1'b0;
        forever #2 clk = ~clk;
    end

    // watchdog, counts every cycle of the run
    initial
    begin
        cycle_count = 0;
        forever
        begin
            @(posedge clk);
            cycle_count++;
            if (cycle_count >= CYCLE_LIMIT)
            begin
                $display("tiff_horizontal_predictor_undo_top test failed");
                $finish;
            end
        end
    end

    // reverse the bytes that make up one sample, upper bytes stay zero
    function automatic logic [31:0] byte_reverse(input logic [31:0] v, input logic [1:0] size);
        logic [31:0] r;
        int          nbytes;
        case (size)
            thpu_pkg::SIZE_8BIT:  nbytes = 1;
            thpu_pkg::SIZE_16BIT: nbytes = 2;
            default:              nbytes = 4;
        endcase
        r = '0;
        for (int i = 0; i < nbytes; i++)
            r[8*i +: 8] = v[8*(nbytes-1-i) +: 8];
        return r;
    endfunction

    // undo the horizontal difference for one sample and advance the position counters
    function automatic thpu_pkg::out_beat_t restore_sample(input logic [31:0] din);
        int unsigned         w;
        int unsigned         h;
        int unsigned         ch;
        int unsigned         ci;
        logic [31:0]         mask;
        logic [31:0]         v;
        logic [31:0]         res;
        bit                  last_ch;
        thpu_pkg::out_beat_t r;
        // zero sizes behave as one, channel count clamps to the history depth
        w  = (cfg_width == 0) ? 1 : cfg_width;
        h  = (cfg_height == 0) ? 1 : cfg_height;
        ch = (cfg_channels == 0) ? 1 : cfg_channels;
        if (ch > HIST_DEPTH)
            ch = HIST_DEPTH;
        case (cfg_size)
            thpu_pkg::SIZE_8BIT:  mask = 32'h0000_00FF;
            thpu_pkg::SIZE_16BIT: mask = 32'h0000_FFFF;
            default:              mask = 32'hFFFF_FFFF;
        endcase
        ci = cfg_planar ? 0 : chan_idx;
        if (ci >= ch)
            ci = ch - 1;
        v = din & mask;
        if (cfg_big)
            v = byte_reverse(v, cfg_size);
        // first pixel of a row passes through
        if (col_cnt != 0)
            v = (v + hist_sample[ci]) & mask;
        hist_sample[ci] = v;
        res = cfg_big ? byte_reverse(v, cfg_size) : v;
        r.sample_out   = res & mask;
        r.end_of_row   = 1'b0;
        r.end_of_image = 1'b0;
        last_ch = cfg_planar || (ci + 1 >= ch);
        if (last_ch)
        begin
            chan_idx = '0;
            // a counter at or past its limit wraps on this step
            if (col_cnt + 1 >= w)
            begin
                col_cnt = '0;
                r.end_of_row = 1'b1;
                if (row_cnt + 1 >= h)
                begin
                    row_cnt = '0;
                    if (!cfg_planar || plane_idx + 1 >= ch)
                    begin
                        plane_idx = '0;
                        r.end_of_image = 1'b1;
                    end
                    else
                    begin
                        plane_idx = plane_idx + 1'b1;
                    end
                end
                else
                begin
                    row_cnt = row_cnt + 1'b1;
                end
            end
            else
            begin
                col_cnt = col_cnt + 1'b1;
            end
        end
        else
        begin
            chan_idx = 3'(ci + 1);
        end
        return r;
    endfunction

    function automatic dir_row_t cfg_row(input thpu_pkg::cfg_index_t idx,
                                         input logic [15:0] data);
        dir_row_t row;
        row.is_cfg = 1'b1;
        row.idx    = idx;
        row.value  = {16'h0000, data};
        row.typed  = 1'b0;
        row.want   = '0;
        return row;
    endfunction

    // typed rows carry the result that can be read off directly
    function automatic dir_row_t beat_row(input logic [31:0] din, input bit typed,
                                          input logic [31:0] want_sample,
                                          input logic eor, input logic eoi);
        dir_row_t row;
        row.is_cfg            = 1'b0;
        row.idx               = thpu_pkg::CFG_IMAGE_WIDTH;
        row.value             = din;
        row.typed             = typed;
        row.want.sample_out   = want_sample;
        row.want.end_of_row   = eor;
        row.want.end_of_image = eoi;
        return row;
    endfunction

    function automatic logic [31:0] draw_sample();
        logic [31:0] d;
        case ($urandom_range(0, 9))
            0:       d = 32'hFFFF_FFFF;
            1:       d = 32'h0000_0000;
            2, 3:    d = $urandom_range(0, 3);
            default: d = $urandom;
        endcase
        return d;
    endfunction

    // one register write at the next edge, caller lowers write_enable after a batch
    task automatic program_reg(input thpu_pkg::cfg_index_t idx, input logic [15:0] data);
        write_enable <= 1'b1;
        reg_index    <= idx;
        write_data   <= data;
        case (idx)
            thpu_pkg::CFG_IMAGE_WIDTH:   cfg_width    = data;
            thpu_pkg::CFG_IMAGE_HEIGHT:  cfg_height   = data;
            thpu_pkg::CFG_CHANNELS:      cfg_channels = data[3:0];
            thpu_pkg::CFG_SAMPLE_SIZE:   cfg_size     = data[1:0];
            thpu_pkg::CFG_BIG_ENDIAN:    cfg_big      = data[0];
            thpu_pkg::CFG_PLANAR_LAYOUT: cfg_planar   = data[0];
            default:                     ;
        endcase
        @(posedge clk);
    endtask

    // drive one sample beat and hold it until the block takes it
    task automatic send_sample(input logic [31:0] din);
        int gap;
        gap = src_idle_en ? $urandom_range(0, MAX_GAP) : 0;
        if (gap > 0)
        begin
            sample_if.valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        sample_if.valid             <= 1'b1;
        sample_if.payload.sample_in <= din;
        do
            @(posedge clk);
        while (!sample_if.ready);
        samples_sent++;
    endtask

    // block is idle once every owed result is back and the pipe has drained
    task automatic wait_idle();
        sample_if.valid <= 1'b0;
        while (pending_results.size() != 0)
            @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    // result side: random stalls per beat, compare each beat with the oldest owed result
    initial
    begin
        thpu_pkg::out_beat_t got;
        thpu_pkg::out_beat_t want;
        int                  stall_left;
        result_if.ready = 1'b0;
        stall_left = 0;
        @(posedge rst_n);
        forever
        begin
            @(posedge clk);
            if (result_if.valid && result_if.ready)
            begin
                got = result_if.payload;
                results_seen++;
                if (got.end_of_row)
                    row_ends_seen++;
                if (got.end_of_image)
                    image_ends_seen++;
                if (pending_results.size() == 0)
                begin
                    $error("result beat with nothing owed: sample_out %h", got.sample_out);
                    error_count++;
                end
                else
                begin
                    want = pending_results.pop_front();
                    if (got.sample_out !== want.sample_out)
                    begin
                        $error("sample_out expected %h actual %h",
                               want.sample_out, got.sample_out);
                        error_count++;
                    end
                    if (got.end_of_row !== want.end_of_row)
                    begin
                        $error("end_of_row expected %b actual %b",
                               want.end_of_row, got.end_of_row);
                        error_count++;
                    end
                    if (got.end_of_image !== want.end_of_image)
                    begin
                        $error("end_of_image expected %b actual %b",
                               want.end_of_image, got.end_of_image);
                        error_count++;
                    end
                end
                stall_left = snk_idle_en ? $urandom_range(0, MAX_GAP) : 0;
            end
            // single update of ready per edge
            if (stall_left > 0)
            begin
                result_if.ready <= 1'b0;
                stall_left--;
            end
            else
            begin
                result_if.ready <= 1'b1;
            end
        end
    end

    // stimulus
    initial
    begin
        dir_row_t            row;
        thpu_pkg::out_beat_t want;
        bit                  in_cfg;
        bit                  whole;
        logic [15:0]         data;
        int                  beats;
        int                  mid_switches;
        longint              total;
        longint              w_eff;
        longint              h_eff;
        longint              ch_eff;

        // every input known from time zero
        rst_n                       = 1'b0;
        write_enable                = 1'b0;
        reg_index                   = '0;
        write_data                  = '0;
        sample_if.valid             = 1'b0;
        sample_if.payload           = '0;
        error_count                 = 0;
        samples_sent                = 0;
        results_seen                = 0;
        row_ends_seen               = 0;
        image_ends_seen             = 0;
        settings_used               = 1;
        mid_switches                = 0;
        src_idle_en                 = 1'b1;
        snk_idle_en                 = 1'b1;

        // register defaults after reset
        cfg_width    = 16'd1;
        cfg_height   = 16'd1;
        cfg_channels = 4'd1;
        cfg_size     = thpu_pkg::SIZE_8BIT;
        cfg_big      = 1'b0;
        cfg_planar   = 1'b0;
        col_cnt      = '0;
        chan_idx     = '0;
        row_cnt      = '0;
        plane_idx    = '0;
        for (int i = 0; i < HIST_DEPTH; i++)
            hist_sample[i] = '0;

        // defaults: one pixel images, 8 bit, little endian, every beat ends the image
        dir_rows.push_back(beat_row(32'hFFFF_FFFF, 1'b1, 32'h0000_00FF, 1'b1, 1'b1));
        dir_rows.push_back(beat_row(32'h0000_0000, 1'b1, 32'h0000_0000, 1'b1, 1'b1));
        dir_rows.push_back(beat_row(32'h1234_56A5, 1'b1, 32'h0000_00A5, 1'b1, 1'b1));
        // 32 bit big endian single pixel: swap and swap back
        dir_rows.push_back(cfg_row(thpu_pkg::CFG_SAMPLE_SIZE, {14'd0, SIZE_32BIT}));
        dir_rows.push_back(cfg_row(thpu_pkg::CFG_BIG_ENDIAN, 16'd1));
        dir_rows.push_back(beat_row(32'h1234_5678, 1'b1, 32'h1234_5678, 1'b1, 1'b1));
        // 16 bit big endian row of three, carry across the swapped bytes
        dir_rows.push_back(cfg_row(thpu_pkg::CFG_IMAGE_WIDTH, 16'd3));
        dir_rows.push_back(cfg_row(thpu_pkg::CFG_SAMPLE_SIZE, {14'd0, thpu_pkg::SIZE_16BIT}));
        dir_rows.push_back(beat_row(32'hABCD_0102, 1'b1, 32'h0000_0102, 1'b0, 1'b0));
        dir_rows.push_back(beat_row(32'h0000_0001, 1'b0, '0, 1'b0, 1'b0));
        dir_rows.push_back(beat_row(32'h0000_FFFF, 1'b0, '0, 1'b0, 1'b0));
        // 32 bit little endian wraparound
        dir_rows.push_back(cfg_row(thpu_pkg::CFG_IMAGE_WIDTH, 16'd2));
        dir_rows.push_back(cfg_row(thpu_pkg::CFG_SAMPLE_SIZE, {14'd0, SIZE_32BIT}));
        dir_rows.push_back(cfg_row(thpu_pkg::CFG_BIG_ENDIAN, 16'd0));
        dir_rows.push_back(beat_row(32'hFFFF_FFFF, 1'b1, 32'hFFFF_FFFF, 1'b0, 1'b0));
        dir_rows.push_back(beat_row(32'h0000_0002, 1'b1, 32'h0000_0001, 1'b1, 1'b1));
        // eight interleaved channels, one pixel: fills every history entry
        dir_rows.push_back(cfg_row(thpu_pkg::CFG_IMAGE_WIDTH, 16'd1));
        dir_rows.push_back(cfg_row(thpu_pkg::CFG_CHANNELS, 16'd8));
        dir_rows.push_back(cfg_row(thpu_pkg::CFG_SAMPLE_SIZE, {14'd0, thpu_pkg::SIZE_8BIT}));
        for (int i = 0; i < 8; i++)
            dir_rows.push_back(beat_row(32'h80 + i, 1'b1, 32'h80 + i, i == 7, i == 7));
        // planar, two planes of one two-pixel row
        dir_rows.push_back(cfg_row(thpu_pkg::CFG_IMAGE_WIDTH, 16'd2));
        dir_rows.push_back(cfg_row(thpu_pkg::CFG_CHANNELS, 16'd2));
        dir_rows.push_back(cfg_row(thpu_pkg::CFG_PLANAR_LAYOUT, 16'd1));
        dir_rows.push_back(beat_row(32'h0000_00F0, 1'b0, '0, 1'b0, 1'b0));
        dir_rows.push_back(beat_row(32'h0000_0020, 1'b0, '0, 1'b0, 1'b0));
        dir_rows.push_back(beat_row(32'h0000_0001, 1'b0, '0, 1'b0, 1'b0));
        dir_rows.push_back(beat_row(32'h0000_00FF, 1'b0, '0, 1'b0, 1'b0));

        repeat (3) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // directed walk
        in_cfg = 1'b0;
        foreach (dir_rows[i])
        begin
            row = dir_rows[i];
            if (row.is_cfg)
            begin
                if (!in_cfg)
                begin
                    wait_idle();
                    settings_used++;
                end
                in_cfg = 1'b1;
                program_reg(row.idx, row.value[15:0]);
            end
            else
            begin
                if (in_cfg)
                    write_enable <= 1'b0;
                in_cfg = 1'b0;
                send_sample(row.value);
                want = restore_sample(row.value);
                pending_results.push_back(row.typed ? row.want : want);
            end
        end
        wait_idle();
        write_enable <= 1'b0;

        // random phases: new settings, then whole images or a cut-off piece of one
        while (samples_sent < RANDOM_BEATS + dir_rows.size())
        begin
            wait_idle();
            settings_used++;
            src_idle_en = $urandom_range(0, 3) != 0;
            snk_idle_en = $urandom_range(0, 3) != 0;
            if ($urandom_range(0, 1) == 1)
            begin
                case ($urandom_range(0, 9))
                    0:       data = 16'hFFFF;
                    1:       data = 16'd0;
                    2:       data = 16'd1;
                    default: data = 16'($urandom_range(1, 12));
                endcase
                program_reg(thpu_pkg::CFG_IMAGE_WIDTH, data);
            end
            if ($urandom_range(0, 1) == 1)
            begin
                case ($urandom_range(0, 9))
                    0:       data = 16'hFFFF;
                    1:       data = 16'd0;
                    default: data = 16'($urandom_range(1, 5));
                endcase
                program_reg(thpu_pkg::CFG_IMAGE_HEIGHT, data);
            end
            if ($urandom_range(0, 1) == 1)
            begin
                data = 16'(($urandom_range(0, 1) == 1) ? $urandom_range(1, 8)
                                                       : $urandom_range(0, 15));
                program_reg(thpu_pkg::CFG_CHANNELS, data);
            end
            if ($urandom_range(0, 1) == 1)
                program_reg(thpu_pkg::CFG_SAMPLE_SIZE, 16'($urandom_range(0, 3)));
            if ($urandom_range(0, 2) == 0)
                program_reg(thpu_pkg::CFG_BIG_ENDIAN, 16'($urandom_range(0, 1)));
            if ($urandom_range(0, 2) == 0)
                program_reg(thpu_pkg::CFG_PLANAR_LAYOUT, 16'($urandom_range(0, 1)));
            // now and then junk in the unused upper write bits
            if ($urandom_range(0, 7) == 0)
            begin
                data = 16'($urandom);
                program_reg(thpu_pkg::CFG_SAMPLE_SIZE, data);
            end
            write_enable <= 1'b0;

            // size of one whole image under the effective settings
            w_eff  = (cfg_width == 0) ? 1 : cfg_width;
            h_eff  = (cfg_height == 0) ? 1 : cfg_height;
            ch_eff = (cfg_channels == 0) ? 1 : ((cfg_channels > HIST_DEPTH) ? HIST_DEPTH
                                                                              : cfg_channels);
            total  = w_eff * h_eff * ch_eff;
            whole  = ($urandom_range(0, 3) != 0) && (total <= 240);
            if (whole)
            begin
                beats = int'(total);
            end
            else
            begin
                // a random count of beats, the next settings may land mid-image
                beats = $urandom_range(1, 60);
                mid_switches++;
            end

            for (int k = 0; k < beats; k++)
            begin
                logic [31:0] din;
                din = draw_sample();
                send_sample(din);
                pending_results.push_back(restore_sample(din));
            end
        end

        wait_idle();

        $display("covered %0d samples in %0d register settings, %0d left mid-image",
                 samples_sent, settings_used, mid_switches);
        $display("checked %0d result beats with %0d row ends and %0d image ends",
                 results_seen, row_ends_seen, image_ends_seen);
        if (error_count == 0)
        begin
            $display("tiff_horizontal_predictor_undo_top test passed");
        end
        else
        begin
            $display("tiff_horizontal_predictor_undo_top test failed");
        end
        $finish;
    end

endmodule

[sim.f]
hdl/thpu_pkg.sv
hdl/thpu_stream_if.sv
hdl/thpu_seq.sv
hdl/tiff_horizontal_predictor_undo_top.sv
verif/testbench.sv
